// ===== rtl/shs_pkg.sv =====
// shs_pkg: types, constants and helper functions of the streaming sha-256 hasher
// no dependencies; imported by every module of the block
package shs_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_POS     = 56;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_WAIT
	} state_t;

	// control from the sequencer into the compression datapath
	typedef struct packed {
		logic       init;
		logic       shift_en;
		logic [7:0] byte_in;
		logic       round_en;
		logic [5:0] round_idx;
	} rnd_ctrl_t;

	localparam logic [31:0] IV_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// sha256_stream_hasher: byte-serial sha-256 with a 64-byte block buffer memory
// a byte that completes no block is taken without a stall; each block is read from the buffer
// memory in a load phase (one buffer memory read per byte), then goes through the rounds and an update
// an end item adds one or two padded blocks, then the digest is loaded once the output is free
// new items are stalled while a block is loaded, hashed and updated, and while a digest waits
// reset: async active low; chaining words go to the initial values, counts to zero
module sha256_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  shs_pkg::in_item_t  item,
	output logic               digest_valid,
	input  logic               digest_stall,
	output shs_pkg::out_item_t digest
);
	import shs_pkg::*;

	state_t           state_q, state_d;
	logic [6:0]       cnt_q;
	logic [5:0]       fill_q, nf;
	logic [60:0]      count_q;
	logic [7:0][31:0] h_q, vars, dig_next;
	logic [6:0]       lim_q;
	logic             mark_q, len_q, fin_q, second_q, pend_q;
	logic [7:0]       buf_mem [BLOCK_BYTES];
	logic [7:0]       rd_q;
	logic             ld_vld_s1;
	logic [5:0]       pos_s1;
	logic             accept, blk_full, out_busy, dig_load;
	logic [63:0]      bits, len_sh;
	logic [5:0]       sh;
	logic [7:0]       ld_byte;
	rnd_ctrl_t        ctrl;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign blk_full   = item.byte_valid && (fill_q == 6'd63);
	assign nf         = fill_q + {5'd0, item.byte_valid};
	assign dig_load   = (state_q == ST_WAIT) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (blk_full || item.end_of_message)) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (cnt_q == 7'd64) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (cnt_q == 7'd63) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (fin_q) state_d = ST_WAIT;
				else if (second_q || pend_q) state_d = ST_LOAD;
				else state_d = ST_IDLE;
			end
			ST_WAIT: begin
				if (!out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 7'd0;
			fill_q    <= 6'd0;
			count_q   <= 61'd0;
			lim_q     <= 7'd0;
			mark_q    <= 1'b0;
			len_q     <= 1'b0;
			fin_q     <= 1'b0;
			second_q  <= 1'b0;
			pend_q    <= 1'b0;
			ld_vld_s1 <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= IV_WORDS[i];
		end else begin
			cnt_q     <= (state_q != state_d) ? 7'd0 : cnt_q + 7'd1;
			ld_vld_s1 <= (state_q == ST_LOAD) && !cnt_q[6];
			if (accept) begin
				if (item.byte_valid) begin
					fill_q  <= nf;
					count_q <= count_q + 61'd1;
				end
				if (blk_full) begin
					lim_q    <= 7'(BLOCK_BYTES);
					mark_q   <= 1'b0;
					len_q    <= 1'b0;
					fin_q    <= 1'b0;
					second_q <= 1'b0;
					pend_q   <= item.end_of_message;
				end else if (item.end_of_message) begin
					lim_q    <= {1'b0, nf};
					mark_q   <= 1'b1;
					len_q    <= (nf < 6'(LEN_POS));
					fin_q    <= (nf < 6'(LEN_POS));
					second_q <= (nf >= 6'(LEN_POS));
				end
			end
			if (state_q == ST_UPDATE) begin
				h_q <= dig_next;
				if (!fin_q) begin
					if (second_q) begin
						// length-only block after a marker that passed the length field
						lim_q    <= 7'd0;
						mark_q   <= 1'b0;
						len_q    <= 1'b1;
						fin_q    <= 1'b1;
						second_q <= 1'b0;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						lim_q  <= {1'b0, fill_q};
						mark_q <= 1'b1;
						len_q  <= 1'b1;
						fin_q  <= 1'b1;
					end
				end
			end
			if (dig_load) begin
				fill_q  <= 6'd0;
				count_q <= 61'd0;
				fin_q   <= 1'b0;
				for (int i = 0; i < 8; i++) h_q[i] <= IV_WORDS[i];
			end
		end
	end

	// block buffer memory, byte writes, registered read
	always_ff @(posedge clk) begin
		if (accept && item.byte_valid) begin
			buf_mem[fill_q] <= item.data_byte;
		end
		rd_q   <= buf_mem[cnt_q[5:0]];
		pos_s1 <= cnt_q[5:0];
	end

	// padding is generated on the fly as bytes leave the buffer
	always_comb begin
		bits   = {count_q, 3'b000};
		sh     = {3'd7 - pos_s1[2:0], 3'b000};
		len_sh = bits >> sh;
		if ({1'b0, pos_s1} < lim_q) ld_byte = rd_q;
		else if (mark_q && ({1'b0, pos_s1} == lim_q)) ld_byte = PAD_BYTE;
		else if (len_q && (pos_s1 >= 6'(LEN_POS))) ld_byte = len_sh[7:0];
		else ld_byte = 8'd0;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) dig_next[i] = h_q[i] + vars[i];
	end

	assign ctrl.init      = (state_q == ST_LOAD) && (cnt_q == 7'd64);
	assign ctrl.shift_en  = ld_vld_s1;
	assign ctrl.byte_in   = ld_byte;
	assign ctrl.round_en  = (state_q == ST_ROUND);
	assign ctrl.round_idx = cnt_q[5:0];

	shs_round u_round (
		.clk  (clk),
		.ctrl (ctrl),
		.hash (h_q),
		.vars (vars)
	);

	shs_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (dig_load),
		.dig          (h_q),
		.busy         (out_busy),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		dig_load |-> !out_busy)
		else $error("digest loaded while words still pending");

	a_shift_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_vld_s1 |-> $past(state_q == ST_LOAD))
		else $error("buffer byte shifted outside a load");

	a_fill_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |=> $stable(fill_q) && $stable(count_q))
		else $error("counts changed during rounds");

endmodule

// ===== rtl/shs_round.sv =====
// shs_round: message schedule window and working variables, one round per cycle
// depends on shs_pkg
module shs_round (
	input  logic                    clk,
	input  shs_pkg::rnd_ctrl_t      ctrl,
	input  logic [7:0][31:0]        hash,
	output logic [7:0][31:0]        vars
);
	import shs_pkg::*;

	// word j of the window sits at blk_q[511-32j -: 32]
	logic [511:0]     blk_q;
	logic [7:0][31:0] v_q;
	logic [31:0]      w0, w1, w9, w14, w_new, t1, t2, ch, maj;

	always_comb begin
		w0    = blk_q[511:480];
		w1    = blk_q[479:448];
		w9    = blk_q[223:192];
		w14   = blk_q[63:32];
		w_new = sml_sig1(w14) + w9 + sml_sig0(w1) + w0;
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sig1(v_q[4]) + ch + ROUND_K[ctrl.round_idx] + w0;
		t2    = big_sig0(v_q[0]) + maj;
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			blk_q <= {blk_q[503:0], ctrl.byte_in};
		end else if (ctrl.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (ctrl.init) begin
			v_q <= hash;
		end else if (ctrl.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;

endmodule

// ===== rtl/shs_out.sv =====
// shs_out: digest register that hands out the eight words one per transaction
// depends on shs_pkg
module shs_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [7:0][31:0]    dig,
	output logic                busy,
	output logic                digest_valid,
	input  logic                digest_stall,
	output shs_pkg::out_item_t  digest
);
	import shs_pkg::*;

	logic [7:0][31:0] dig_q;
	logic [2:0]       idx_q;
	logic             valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 3'd0;
		end else if (valid_q && !digest_stall) begin
			if (idx_q == 3'd7) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= dig;
		end
	end

	assign busy                = valid_q;
	assign digest_valid        = valid_q;
	assign digest.digest_word  = dig_q[idx_q];
	assign digest.word_index   = idx_q;
	assign digest.last_word    = (idx_q == 3'd7);

endmodule
